// ===== design/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants of the UTF-8 to UTF-16 transcoder
// Command format passed from the decode front end to the unit emitter.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   // default width of the capacity register and the unit counter
   localparam int CAPACITY_BITS_DEF = 16;
   // capacity after reset, in 16-bit units
   localparam int CAP_RESET         = 65535;
   // entries in the command queue between decoder and emitter
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [15:0] SPACE_UNIT = 16'h0020;
   localparam logic [15:0] HI_SURR_BASE = 16'hD7C0;
   localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
   localparam logic [30:0] MAX_CODE_POINT = 31'h10FFFF;

   // what the emitter does after any replacement spaces of a command
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_UNIT,
      ACT_PAIR,
      ACT_ERROR,
      ACT_TERM
   } u8u16_act_type;

   typedef struct packed {
      logic [2:0]    spaces;   // replacement spaces ahead of the action
      u8u16_act_type act;
      logic [15:0]   unit0;    // single unit, or high surrogate
      logic [15:0]   unit1;    // low surrogate
   } u8u16_cmd_type;

endpackage

// ===== design/u8u16_if.sv =====
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Byte request, unit response and capacity register write channels.
// ----------------------------------------------------------------------------
interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;

   modport source (output valid, output byte_value, input ready);
   modport sink   (input valid, input byte_value, output ready);
endinterface

interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        is_last;
   logic        range_error;
   logic [15:0] units_written;

   modport source (output valid, output code_unit, output is_last,
                   output range_error, output units_written, input ready);
   modport sink   (input valid, input code_unit, input is_last,
                   input range_error, input units_written, output ready);
endinterface

interface u8u16_csr_if #(
   parameter int DATA_BITS = u8u16_pkg::CAPACITY_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/u8u16_front.sv =====
// ----------------------------------------------------------------------------
// u8u16_front: UTF-8 sequence decoder
// Takes one byte per transfer, gathers sequences and queues emit commands.
// ----------------------------------------------------------------------------
module u8u16_front (
   input  logic                    clock,
   input  logic                    reset,
   u8u16_req_if.sink               req_if,
   input  logic                    full_i,
   output logic                    push_o,
   output u8u16_pkg::u8u16_cmd_type cmd_o
);

   logic [30:0] acc_ff, acc_in;
   logic [2:0]  need_ff, need_in;
   logic [2:0]  taken_ff, taken_in;

   logic        accept;
   logic        fresh;
   logic [2:0]  taken_p1;
   logic [30:0] acc_cat;
   logic [7:0]  b;

   assign b        = req_if.byte_value;
   assign req_if.ready = !full_i;
   assign accept   = req_if.valid && !full_i;
   assign taken_p1 = taken_ff + 3'd1;
   assign acc_cat  = {acc_ff[24:0], b[5:0]};

   always_comb begin
      acc_in      = acc_ff;
      need_in     = need_ff;
      taken_in    = taken_ff;
      cmd_o.spaces = 3'd0;
      cmd_o.act   = u8u16_pkg::ACT_NONE;
      cmd_o.unit0 = 16'd0;
      cmd_o.unit1 = 16'd0;
      fresh       = 1'b0;

      if (need_ff != 3'd0) begin
         if (b[7:6] == 2'b10) begin
            acc_in   = acc_cat;
            taken_in = taken_p1;
            if (taken_p1 >= need_ff) begin
               acc_in   = 31'd0;
               need_in  = 3'd0;
               taken_in = 3'd0;
               if (acc_cat[30:16] == 15'd0) begin
                  cmd_o.act   = u8u16_pkg::ACT_UNIT;
                  cmd_o.unit0 = acc_cat[15:0];
               end else if (acc_cat <= u8u16_pkg::MAX_CODE_POINT) begin
                  cmd_o.act   = u8u16_pkg::ACT_PAIR;
                  cmd_o.unit0 = u8u16_pkg::HI_SURR_BASE + {5'd0, acc_cat[20:10]};
                  cmd_o.unit1 = u8u16_pkg::LO_SURR_BASE + {6'd0, acc_cat[9:0]};
               end else begin
                  cmd_o.act = u8u16_pkg::ACT_ERROR;
               end
            end
         end else begin
            // broken sequence: lead plus continuations taken become spaces
            cmd_o.spaces = taken_p1;
            acc_in       = 31'd0;
            need_in      = 3'd0;
            taken_in     = 3'd0;
            fresh        = 1'b1;
         end
      end else begin
         fresh = 1'b1;
      end

      if (fresh) begin
         priority if (b == 8'd0) begin
            cmd_o.act = u8u16_pkg::ACT_TERM;
         end else if (!b[7]) begin
            cmd_o.act   = u8u16_pkg::ACT_UNIT;
            cmd_o.unit0 = {8'd0, b};
         end else if (b[7:5] == 3'b110) begin
            need_in  = 3'd1;
            taken_in = 3'd0;
            acc_in   = {26'd0, b[4:0]};
         end else if (b[7:4] == 4'b1110) begin
            need_in  = 3'd2;
            taken_in = 3'd0;
            acc_in   = {27'd0, b[3:0]};
         end else if (b[7:3] == 5'b11110) begin
            need_in  = 3'd3;
            taken_in = 3'd0;
            acc_in   = {28'd0, b[2:0]};
         end else if (b[7:2] == 6'b111110) begin
            need_in  = 3'd4;
            taken_in = 3'd0;
            acc_in   = {29'd0, b[1:0]};
         end else if (b[7:1] == 7'b1111110) begin
            need_in  = 3'd5;
            taken_in = 3'd0;
            acc_in   = {30'd0, b[0]};
         end else begin
            // stray continuation, 0xFE or 0xFF
            cmd_o.act   = u8u16_pkg::ACT_UNIT;
            cmd_o.unit0 = u8u16_pkg::SPACE_UNIT;
         end
      end
   end

   assign push_o = accept && (cmd_o.spaces != 3'd0 || cmd_o.act != u8u16_pkg::ACT_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= 31'd0;
         need_ff  <= 3'd0;
         taken_ff <= 3'd0;
      end else if (accept) begin
         acc_ff   <= acc_in;
         need_ff  <= need_in;
         taken_ff <= taken_in;
      end
   end

   a_taken_below_need: assert property (@(posedge clock) disable iff (reset)
      need_ff != 3'd0 |-> taken_ff < need_ff)
      else $error("continuation count reached sequence length");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      need_ff == 3'd0 |-> taken_ff == 3'd0 && acc_ff == 31'd0)
      else $error("decoder state left over outside a sequence");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push_o |-> !full_i)
      else $error("command pushed into full queue");

endmodule

// ===== design/u8u16_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16_queue: command queue
// Small FIFO between decoder and emitter, head visible without a read delay.
// ----------------------------------------------------------------------------
module u8u16_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_i,
   input  u8u16_pkg::u8u16_cmd_type push_cmd_i,
   output logic                     full_o,
   input  logic                     pop_i,
   output logic                     head_valid_o,
   output u8u16_pkg::u8u16_cmd_type head_cmd_o
);

   localparam int DEPTH = u8u16_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u8u16_pkg::u8u16_cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;

   assign full_o       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid_o = (cnt_ff != '0);
   assign head_cmd_o   = slot_ff[rd_ff];
   assign do_pop       = pop_i && head_valid_o;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push_i) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push_i && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (!push_i && do_pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         slot_ff[wr_ff] <= push_cmd_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue fill beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> wr_ff == rd_ff)
      else $error("empty queue with pointers apart");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> head_valid_o)
      else $error("pop from empty queue");

endmodule

// ===== design/u8u16_back.sv =====
// ----------------------------------------------------------------------------
// u8u16_back: UTF-16 unit emitter
// Plays queued commands one unit per cycle, rsp allowing, under capacity limit.
// ----------------------------------------------------------------------------
module u8u16_back #(
   parameter int CAPACITY_BITS = u8u16_pkg::CAPACITY_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CAPACITY_BITS-1:0] cap_i,
   input  logic                     head_valid_i,
   input  u8u16_pkg::u8u16_cmd_type head_cmd_i,
   output logic                     pop_o,
   u8u16_rsp_if.source              rsp_if
);

   localparam int CW = CAPACITY_BITS + 2;

   logic [CAPACITY_BITS-1:0] count_ff, count_in;
   logic                     stopped_ff, stopped_in;
   logic                     rdone_ff, rdone_in;
   logic                     second_ff, second_in;
   logic [2:0]               slot_ff, slot_in;

   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_unit_ff, out_unit_in;
   logic        out_last_ff, out_last_in;
   logic        out_err_ff, out_err_in;
   logic [15:0] out_cnt_ff, out_cnt_in;

   logic                     can_out;
   logic                     load;
   logic                     blocked;
   logic                     room1, room2;
   logic [CAPACITY_BITS-1:0] eff_cap;
   logic [2:0]               slot_p1;

   assign can_out = !out_valid_ff || rsp_if.ready;
   assign blocked = stopped_ff || rdone_ff;
   assign eff_cap = (cap_i == '0) ? CAPACITY_BITS'(1) : cap_i;
   assign room1   = (CW'(count_ff) + CW'(1)) < CW'(eff_cap);
   assign room2   = (CW'(count_ff) + CW'(2)) < CW'(eff_cap);
   assign slot_p1 = slot_ff + 3'd1;

   always_comb begin
      count_in    = count_ff;
      stopped_in  = stopped_ff;
      rdone_in    = rdone_ff;
      second_in   = second_ff;
      slot_in     = slot_ff;
      pop_o       = 1'b0;
      load        = 1'b0;
      out_unit_in = 16'd0;
      out_last_in = 1'b0;
      out_err_in  = 1'b0;
      out_cnt_in  = 16'd0;

      if (head_valid_i && can_out) begin
         if (second_ff) begin
            // low surrogate: room was reserved with the high one
            load        = 1'b1;
            out_unit_in = head_cmd_i.unit1;
            count_in    = count_ff + CAPACITY_BITS'(1);
            second_in   = 1'b0;
            pop_o       = 1'b1;
         end else if (slot_ff < head_cmd_i.spaces) begin
            if (!blocked) begin
               if (room1) begin
                  load        = 1'b1;
                  out_unit_in = u8u16_pkg::SPACE_UNIT;
                  count_in    = count_ff + CAPACITY_BITS'(1);
               end else begin
                  stopped_in = 1'b1;
               end
            end
            slot_in = slot_p1;
            if (slot_p1 == head_cmd_i.spaces && head_cmd_i.act == u8u16_pkg::ACT_NONE) begin
               pop_o = 1'b1;
            end
         end else begin
            unique case (head_cmd_i.act)
               u8u16_pkg::ACT_UNIT: begin
                  if (!blocked) begin
                     if (room1) begin
                        load        = 1'b1;
                        out_unit_in = head_cmd_i.unit0;
                        count_in    = count_ff + CAPACITY_BITS'(1);
                     end else begin
                        stopped_in = 1'b1;
                     end
                  end
                  pop_o = 1'b1;
               end
               u8u16_pkg::ACT_PAIR: begin
                  if (!blocked && room2) begin
                     load        = 1'b1;
                     out_unit_in = head_cmd_i.unit0;
                     count_in    = count_ff + CAPACITY_BITS'(1);
                     second_in   = 1'b1;
                  end else begin
                     if (!blocked) begin
                        stopped_in = 1'b1;
                     end
                     pop_o = 1'b1;
                  end
               end
               u8u16_pkg::ACT_ERROR: begin
                  if (!blocked) begin
                     load        = 1'b1;
                     out_last_in = 1'b1;
                     out_err_in  = 1'b1;
                     out_cnt_in  = 16'(count_ff);
                     rdone_in    = 1'b1;
                  end
                  pop_o = 1'b1;
               end
               u8u16_pkg::ACT_TERM: begin
                  if (!rdone_ff) begin
                     load        = 1'b1;
                     out_last_in = 1'b1;
                     out_cnt_in  = 16'(count_ff);
                  end
                  count_in   = '0;
                  stopped_in = 1'b0;
                  rdone_in   = 1'b0;
                  pop_o      = 1'b1;
               end
               default: begin
                  pop_o = 1'b1;
               end
            endcase
         end
         if (pop_o) begin
            slot_in = 3'd0;
         end
      end
   end

   assign out_valid_in = load || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         stopped_ff   <= 1'b0;
         rdone_ff     <= 1'b0;
         second_ff    <= 1'b0;
         slot_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         stopped_ff   <= stopped_in;
         rdone_ff     <= rdone_in;
         second_ff    <= second_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_unit_ff <= out_unit_in;
         out_last_ff <= out_last_in;
         out_err_ff  <= out_err_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.code_unit     = out_unit_ff;
   assign rsp_if.is_last       = out_last_ff;
   assign rsp_if.range_error   = out_err_ff;
   assign rsp_if.units_written = out_cnt_ff;

   a_pair_holds_head: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> head_valid_i && !rdone_ff && !stopped_ff)
      else $error("low surrogate pending without its command");

   a_low_surrogate: assert property (@(posedge clock) disable iff (reset)
      (can_out && head_valid_i && second_ff) |=>
         rsp_if.valid && rsp_if.code_unit[15:10] == 6'b110111)
      else $error("second unit of a pair is not a low surrogate");

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      (pop_o && !second_ff && slot_ff >= head_cmd_i.spaces &&
       head_cmd_i.act == u8u16_pkg::ACT_TERM) |=>
         count_ff == '0 && !stopped_ff && !rdone_ff)
      else $error("string state not cleared at terminator");

endmodule

// ===== design/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder: streaming UTF-8 to UTF-16 converter
// Byte-in, code-unit-out transcoder with a capacity limit and unit count.
// ----------------------------------------------------------------------------
// One UTF-8 byte of a NUL-terminated string arrives per req transfer; UTF-16
// code units leave on rsp, one per transfer, with is_last set on the
// terminator (carrying units_written) or on the single range-error result.
// A decode front end takes one byte every cycle while its command queue
// (QUEUE_DEPTH entries) has room and turns each byte into at most one
// command; an emitter plays each command out at one unit per cycle while the
// receiver is ready. Plain text streams at one byte per cycle; a byte that
// yields several results (a surrogate pair, or up to five spaces for a broken
// sequence plus the byte itself) holds the emitter while the queue keeps
// taking input. Commands whose units the capacity limit drops still pass
// through the emitter. The response register lets a new unit load in the
// same cycle the previous one transfers. The user must write the capacity
// register through csr only while the block is idle, which the block does
// not enforce; it takes effect on the next byte, no clearing pass at reset.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder #(
   parameter int CAPACITY_BITS = u8u16_pkg::CAPACITY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   u8u16_req_if.sink   req_if,
   u8u16_rsp_if.source rsp_if,
   u8u16_csr_if.sink   csr_if
);

   // capacity register, counted in 16-bit units including the terminator
   logic [CAPACITY_BITS-1:0] cap_ff;

   // front end to queue
   logic                     q_push;
   logic                     q_full;
   u8u16_pkg::u8u16_cmd_type q_push_cmd;

   // queue to emitter
   logic                     q_pop;
   logic                     q_head_valid;
   u8u16_pkg::u8u16_cmd_type q_head_cmd;

   // writes are always taken
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_BITS'(u8u16_pkg::CAP_RESET);
      end else if (csr_if.valid) begin
         cap_ff <= CAPACITY_BITS'(csr_if.data);
      end
   end

   // byte decode: sequence gathering, lead classification, surrogate split
   u8u16_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .full_i (q_full),
      .push_o (q_push),
      .cmd_o  (q_push_cmd)
   );

   // absorbs bursts of multi-unit commands
   u8u16_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_i       (q_push),
      .push_cmd_i   (q_push_cmd),
      .full_o       (q_full),
      .pop_i        (q_pop),
      .head_valid_o (q_head_valid),
      .head_cmd_o   (q_head_cmd)
   );

   // unit emission: capacity check, stop and error state, unit count
   u8u16_back #(
      .CAPACITY_BITS (CAPACITY_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cap_i        (cap_ff),
      .head_valid_i (q_head_valid),
      .head_cmd_i   (q_head_cmd),
      .pop_o        (q_pop),
      .rsp_if       (rsp_if)
   );

endmodule

// ===== tb/u8u16_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// u8u16_unit_checker: code unit predictor and checker for the transcoder
// Watches the byte, unit and capacity channels, predicts the UTF-16 units of
// every accepted byte and compares each unit transfer against the oldest one.
// ----------------------------------------------------------------------------
module u8u16_unit_checker (
   input  logic clock,
   input  logic reset,
   u8u16_req_if req_mon,
   u8u16_rsp_if rsp_mon,
   u8u16_csr_if csr_mon,
   output int   mismatch_count,
   output int   units_outstanding
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_last;
      logic        range_error;
      logic [15:0] units_written;
   } unit_rec_type;

   unit_rec_type unit_q[$];

   // shadow of the capacity register and the string decode state
   logic [15:0] capacity;
   logic [30:0] code_accum;
   int unsigned cont_needed;
   int unsigned cont_taken;
   logic [16:0] unit_count;
   logic        out_stopped;
   logic        range_hit;

   function automatic logic [16:0] cap_limit();
      return (capacity == 16'd0) ? 17'd1 : {1'b0, capacity};
   endfunction

   function automatic void push_unit(logic [15:0] u, logic last, logic err,
                                     logic [15:0] cnt);
      unit_rec_type r;
      r.code_unit     = u;
      r.is_last       = last;
      r.range_error   = err;
      r.units_written = cnt;
      unit_q.push_back(r);
   endfunction

   function automatic void put_single(logic [15:0] u);
      if (out_stopped) return;
      if (unit_count + 17'd1 < cap_limit()) begin
         push_unit(u, 1'b0, 1'b0, 16'd0);
         unit_count++;
      end else begin
         out_stopped = 1'b1;
      end
   endfunction

   // no partial pair: both halves fit or output stops
   function automatic void put_pair(logic [30:0] cp);
      if (out_stopped) return;
      if (unit_count + 17'd2 < cap_limit()) begin
         push_unit({5'd0, cp[20:10]} + u8u16_pkg::HI_SURR_BASE, 1'b0, 1'b0, 16'd0);
         push_unit({6'd0, cp[9:0]} + u8u16_pkg::LO_SURR_BASE, 1'b0, 1'b0, 16'd0);
         unit_count += 17'd2;
      end else begin
         out_stopped = 1'b1;
      end
   endfunction

   function automatic void close_point(logic [30:0] cp);
      if (cp <= 31'h0000FFFF) begin
         put_single(cp[15:0]);
      end else if (cp <= u8u16_pkg::MAX_CODE_POINT) begin
         put_pair(cp);
      end else if (!out_stopped) begin
         push_unit(16'd0, 1'b1, 1'b1, unit_count[15:0]);
         range_hit = 1'b1;
      end
   endfunction

   function automatic void clear_string();
      code_accum  = '0;
      cont_needed = 0;
      cont_taken  = 0;
      unit_count  = '0;
      out_stopped = 1'b0;
      range_hit   = 1'b0;
   endfunction

   function automatic void predict_byte(logic [7:0] b);
      int unsigned lead_len;
      int unsigned spaces;
      logic [30:0] cp;
      if (cont_needed != 0) begin
         if (b[7:6] == 2'b10) begin
            code_accum = {code_accum[24:0], b[5:0]};
            cont_taken++;
            if (cont_taken >= cont_needed) begin
               cp          = code_accum;
               cont_needed = 0;
               cont_taken  = 0;
               code_accum  = '0;
               close_point(cp);
            end
            return;
         end
         // broken sequence: a space for the lead and each continuation,
         // then the breaking byte is decoded normally
         spaces      = cont_taken + 1;
         cont_needed = 0;
         cont_taken  = 0;
         code_accum  = '0;
         for (int i = 0; i < spaces; i++) put_single(u8u16_pkg::SPACE_UNIT);
      end
      if (b == 8'h00) begin
         if (!range_hit) push_unit(16'd0, 1'b1, 1'b0, unit_count[15:0]);
         clear_string();
         return;
      end
      if (out_stopped || range_hit) return;
      if (!b[7]) begin
         put_single({8'h00, b});
         return;
      end
      casez (b)
         8'b110?????: lead_len = 1;
         8'b1110????: lead_len = 2;
         8'b11110???: lead_len = 3;
         8'b111110??: lead_len = 4;
         8'b1111110?: lead_len = 5;
         default:     lead_len = 0;
      endcase
      if (lead_len == 0) begin
         put_single(u8u16_pkg::SPACE_UNIT);
         return;
      end
      cont_needed = lead_len;
      cont_taken  = 0;
      code_accum  = {23'd0, b & (8'h1F >> (lead_len - 1))};
   endfunction

   function automatic void flag_result(string why, unit_rec_type want,
                                       unit_rec_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $write("%0t: %s: expected unit=%h last=%b err=%b count=%0d, ",
                $realtime, why, want.code_unit, want.is_last, want.range_error,
                want.units_written);
         $display("got unit=%h last=%b err=%b count=%0d",
                  got.code_unit, got.is_last, got.range_error, got.units_written);
      end
   endfunction

   always @(posedge clock) begin
      unit_rec_type got;
      unit_rec_type want;
      if (reset) begin
         capacity       = 16'(u8u16_pkg::CAP_RESET);
         mismatch_count = 0;
         clear_string();
         unit_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) capacity = csr_mon.data;
         if (req_mon.valid && req_mon.ready) predict_byte(req_mon.byte_value);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.code_unit     = rsp_mon.code_unit;
            got.is_last       = rsp_mon.is_last;
            got.range_error   = rsp_mon.range_error;
            got.units_written = rsp_mon.units_written;
            if (unit_q.size() == 0) begin
               flag_result("unit transfer with none expected", '0, got);
            end else begin
               want = unit_q.pop_front();
               if (got.code_unit !== want.code_unit || got.is_last !== want.is_last ||
                   got.range_error !== want.range_error ||
                   got.units_written !== want.units_written)
                  flag_result("unit mismatch", want, got);
            end
         end
      end
      units_outstanding = unit_q.size();
   end

endmodule

// ===== tb/utf8_to_utf16_transcoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_tb: stimulus and verdict for the UTF-8 transcoder
// Feeds directed and random NUL-terminated strings under several capacity
// settings with random idling on both channels; a checker module predicts
// and compares every code unit.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_tb;

   localparam int IDLE_LIMIT      = 2000;  // cycles without any transfer
   localparam int HOLD_CYCLES     = 200;   // long receiver hold-off
   localparam int SETTLE_CYCLES   = 32;    // no-unit bytes still in flight
   localparam int N_PHASES        = 7;
   localparam int BYTES_PER_PHASE = 8;
   localparam int PRESSURE_PHASE  = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   u8u16_req_if req_bus ();
   u8u16_rsp_if rsp_bus ();
   u8u16_csr_if #(.DATA_BITS(u8u16_pkg::CAPACITY_BITS_DEF)) csr_bus ();

   int          mismatch_count;
   int          units_outstanding;
   int          idle_cycles = 0;
   int          stall_left  = 0;
   logic        sink_stalls  = 1'b0;   // random receiver stalls enabled
   logic        src_gaps     = 1'b0;   // random sender gaps enabled
   logic        hold_request = 1'b0;   // ask the receiver for a long hold-off
   logic [7:0]  string_bytes[$];
   logic [15:0] phase_caps[N_PHASES];

   utf8_to_utf16_transcoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   u8u16_unit_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .csr_mon           (csr_bus),
      .mismatch_count    (mismatch_count),
      .units_outstanding (units_outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   // Receiver: ready is updated at each falling edge. A pending hold-off
   // request takes priority over random stalls and is counted here.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else if (hold_request) begin
         hold_request  = 1'b0;
         stall_left    = HOLD_CYCLES - 1;
         rsp_bus.ready = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
         stall_left    = gap_length() - 1;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // Watchdog: any transfer on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one byte, optionally after a gap, and return at the rising edge
   // of its transfer. valid stays high; the next call or idle_req decides.
   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = (src_gaps && $urandom_range(0, 3) == 0) ? gap_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.byte_value = b;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic idle_req();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic send_string();
      foreach (string_bytes[i]) send_byte(string_bytes[i]);
   endtask

   // Capacity writes only with the block drained: all units in, plus a
   // SETTLE_CYCLES wait for bytes that produce nothing.
   task automatic write_capacity(logic [15:0] value);
      idle_req();
      wait (units_outstanding == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Random string: mostly well-formed characters, some bad leads, cut-short
   // sequences and raw noise, always closed by NUL.
   task automatic make_string();
      int         n_chars;
      int         kind;
      int         len;
      int         conts;
      logic       cut;
      logic [7:0] lead;
      string_bytes.delete();
      n_chars = $urandom_range(0, 6);
      repeat (n_chars) begin
         len  = 0;
         kind = $urandom_range(0, 99);
         cut  = (kind >= 93 && kind < 97);
         if (cut) kind = $urandom_range(35, 86);
         if (kind < 35) begin
            lead = 8'($urandom_range(1, 127));
         end else if (kind < 55) begin
            lead = {3'b110, 5'($urandom)};
            len  = 1;
         end else if (kind < 70) begin
            lead = {4'b1110, 4'($urandom)};
            len  = 2;
         end else if (kind < 82) begin
            // F0..F4 keeps most 4-byte points in range
            lead = {5'b11110, 3'($urandom_range(0, 4))};
            len  = 3;
         end else if (kind < 87) begin
            // 5 and 6 byte forms, nearly always above the code space
            if ($urandom_range(0, 1) == 1) begin
               lead = {6'b111110, 2'($urandom)};
               len  = 4;
            end else begin
               lead = {7'b1111110, 1'($urandom)};
               len  = 5;
            end
         end else if (kind < 93) begin
            case ($urandom_range(0, 2))
               0:       lead = 8'hFE;
               1:       lead = 8'hFF;
               default: lead = 8'($urandom_range(8'h80, 8'hBF));
            endcase
         end else begin
            lead = 8'($urandom_range(1, 255));
         end
         string_bytes.push_back(lead);
         conts = cut ? $urandom_range(0, len - 1) : len;
         repeat (conts) string_bytes.push_back({2'b10, 6'($urandom)});
      end
      string_bytes.push_back(8'h00);
   endtask

   initial begin
      int sent;
      req_bus.valid      = 1'b0;
      req_bus.byte_value = 8'h00;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.data       = '0;

      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed, at the reset capacity, no idling:
      // max ASCII, 2/3-byte points, highest valid pair; bad leads,
      // sequence broken by ASCII and by NUL; 5-byte point out of range
      // with the rest of its string ignored.
      string_bytes = '{8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                       8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00};
      send_string();
      string_bytes = '{8'hFF, 8'h80, 8'hE2, 8'h82, 8'h41, 8'hC3, 8'h00};
      send_string();
      string_bytes = '{8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'h41, 8'h00};
      send_string();

      // Random phases over capacity settings: full size, the smallest,
      // zero (acts as one), full size with a long receiver hold-off,
      // and a few small buffers that cut strings short.
      phase_caps[0] = 16'hFFFF;
      phase_caps[1] = 16'd1;
      phase_caps[2] = 16'd0;
      phase_caps[3] = 16'hFFFF;
      phase_caps[4] = 16'd4;
      phase_caps[5] = 16'($urandom_range(2, 12));
      phase_caps[6] = 16'd3;

      for (int phase = 0; phase < N_PHASES; phase++) begin
         write_capacity(phase_caps[phase]);
         // first phase runs without idling on either side
         src_gaps    = (phase != 0);
         sink_stalls = (phase != 0);
         if (phase == PRESSURE_PHASE) begin
            // sender keeps offering while the receiver holds off
            src_gaps     = 1'b0;
            hold_request = 1'b1;
         end
         sent = 0;
         while (sent < BYTES_PER_PHASE) begin
            make_string();
            send_string();
            sent += string_bytes.size();
         end
      end

      idle_req();
      wait (units_outstanding == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && units_outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/u8u16_pkg.sv
design/u8u16_if.sv
design/u8u16_front.sv
design/u8u16_queue.sv
design/u8u16_back.sv
design/utf8_to_utf16_transcoder.sv
tb/u8u16_unit_checker.sv
tb/utf8_to_utf16_transcoder_tb.sv
